// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/chct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chct_pkg
// Types and constants of the call-site hit counter table.
// ----------------------------------------------------------------------------
package chct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 32;
  localparam int TICKS_W = 16;

  // input word codes
  localparam logic CMD_HIT  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register decode on paddr[2]
  localparam int   PADDR_W      = 3;
  localparam logic REG_ROLLOVER = 1'b0;
  localparam logic [TICKS_W-1:0] ROLLOVER_RESET = 16'd60;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch word, read entry zero
    logic proc;   // apply update of the entry under check
    logic adv;    // move on to next entry
    logic flush;  // move held report out as the final one
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic match;
    logic empty;
    logic roll;
    logic last_idx;
    logic pend_valid;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/chct_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chct_ctrl
// Sequencer: accepts one word, steps the entry scan, flushes the last report.
// ----------------------------------------------------------------------------
module chct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  chct_pkg::ctl_sts_t  sts,
  output chct_pkg::ctl_cmd_t  cmd_bus
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   blocked;

  // a rolled entry cannot displace the held report while the output is full
  assign blocked = sts.is_tick && sts.roll && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_next = state;
    cmd_bus    = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_bus.load = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.is_tick) begin
          cmd_bus.proc = 1'b1;
          if (sts.match || sts.empty || sts.last_idx) begin
            state_next = ST_IDLE;
          end else begin
            cmd_bus.adv = 1'b1;
          end
        end else if (!blocked) begin
          cmd_bus.proc = 1'b1;
          if (sts.last_idx) begin
            state_next = ST_FLUSH;
          end else begin
            cmd_bus.adv = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd_bus.flush = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ----- rtl/chct_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chct_dp
// Entry memory, scan index, entry update, held report and output register.
// ----------------------------------------------------------------------------
module chct_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  chct_pkg::ctl_cmd_t                    cmd_bus,
  output chct_pkg::ctl_sts_t                    sts,
  input  logic [chct_pkg::TICKS_W-1:0]          rollover_ticks,
  input  logic                                  cmd,
  input  logic [chct_pkg::ADDR_W-1:0]           address,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [chct_pkg::ADDR_W-1:0]           report_address,
  output logic [chct_pkg::COUNT_W-1:0]          report_count,
  output logic [chct_pkg::TICKS_W-1:0]          report_ticks,
  output logic                                  last
);

  chct_pkg::entry_t ent_mem [chct_pkg::ENTRIES];
  logic [chct_pkg::ENTRIES-1:0] ent_vld;

  logic                           cmd_q;
  logic [chct_pkg::ADDR_W-1:0]    addr_q;
  logic [chct_pkg::IDX_W-1:0]     chk_idx;
  logic [chct_pkg::IDX_W-1:0]     rd_addr;
  chct_pkg::entry_t               rd_data;
  logic                           rd_vld;
  chct_pkg::entry_t               eff;
  chct_pkg::entry_t               wr_data;
  chct_pkg::entry_t               rep;
  chct_pkg::entry_t               pend;
  logic                           pend_valid;
  logic                           wr_en;
  logic                           is_tick;
  logic                           match;
  logic                           empty;
  logic                           roll;
  logic                           out_free;
  logic                           load_out;
  logic [chct_pkg::COUNT_W-1:0]   count_inc;
  logic [chct_pkg::TICKS_W-1:0]   ticks_inc;

  // an entry never written reads as all zero
  assign eff     = rd_vld ? rd_data : '0;
  assign is_tick = (cmd_q == chct_pkg::CMD_TICK);
  assign match   = (eff.addr == addr_q);
  assign empty   = (eff.addr == '0);

  assign count_inc = (eff.count == '1) ? eff.count : eff.count + 1'b1;
  assign ticks_inc = (eff.ticks == '1) ? eff.ticks : eff.ticks + 1'b1;

  assign roll     = is_tick && !empty && (ticks_inc >= rollover_ticks);
  assign out_free = !out_valid || !out_stall;

  assign rep.addr  = eff.addr;
  assign rep.count = eff.count;
  assign rep.ticks = ticks_inc;

  always_comb begin
    wr_data = '0;
    wr_en   = 1'b0;
    if (cmd_bus.proc) begin
      if (!is_tick) begin
        if (match) begin
          wr_en         = 1'b1;
          wr_data.addr  = eff.addr;
          wr_data.count = count_inc;
          wr_data.ticks = eff.ticks;
        end else if (empty) begin
          wr_en         = 1'b1;
          wr_data.addr  = addr_q;
          wr_data.count = chct_pkg::COUNT_W'(1);
          wr_data.ticks = '0;
        end
      end else if (!empty) begin
        wr_en = 1'b1;
        if (!roll) begin
          wr_data.addr  = eff.addr;
          wr_data.count = eff.count;
          wr_data.ticks = ticks_inc;
        end
      end
    end
  end

  // re-read the same entry while held, so the registered data stays current
  always_comb begin
    if (cmd_bus.load) begin
      rd_addr = '0;
    end else if (cmd_bus.adv) begin
      rd_addr = chk_idx + 1'b1;
    end else begin
      rd_addr = chk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[chk_idx] <= wr_data;
    end
    rd_data <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld[chk_idx] <= 1'b1;
      end
      rd_vld <= ent_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.load) begin
      cmd_q   <= cmd;
      addr_q  <= address;
      chk_idx <= '0;
    end else if (cmd_bus.adv) begin
      chk_idx <= chk_idx + 1'b1;
    end
  end

  // one report is held back until the next one shows whether it is the last
  assign load_out = (cmd_bus.proc && roll && pend_valid) || cmd_bus.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd_bus.proc && roll) begin
        pend_valid <= 1'b1;
      end else if (cmd_bus.flush) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.proc && roll) begin
      pend <= rep;
    end
    if (load_out) begin
      report_address <= pend.addr;
      report_count   <= pend.count;
      report_ticks   <= pend.ticks;
      last           <= cmd_bus.flush;
    end
  end

  assign sts.is_tick    = is_tick;
  assign sts.match      = match;
  assign sts.empty      = empty;
  assign sts.roll       = roll;
  assign sts.last_idx   = (chk_idx == chct_pkg::LAST_IDX);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

endmodule

// ----- rtl/call_site_hit_counter_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_site_hit_counter_table_top
// Per-address hit counter table with tick-driven rollover reports.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         in_valid/in_stall   cmd, address
// report    out        out_valid/out_stall report_address, report_count,
//                                          report_ticks, last
// config    in         apb psel/penable    paddr, pwdata, prdata
//
// one word at a time; the scan visits one entry per cycle through the single
// read port of the entry memory, except that a tick scan holds on an entry
// that rolls over while a report is held and out_stall keeps the output full
// synchronous reset empties the table at once through per-entry valid bits
// a finished report waits in the output register while the scan continues
// ----------------------------------------------------------------------------
module call_site_hit_counter_table_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [chct_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic [chct_pkg::ADDR_W-1:0]          address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [chct_pkg::ADDR_W-1:0]          report_address,
  output logic [chct_pkg::COUNT_W-1:0]         report_count,
  output logic [chct_pkg::TICKS_W-1:0]         report_ticks,
  output logic                                 last
);

  logic [chct_pkg::TICKS_W-1:0] rollover_ticks;
  chct_pkg::ctl_cmd_t           cmd_bus;
  chct_pkg::ctl_sts_t           sts;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_ticks <= chct_pkg::ROLLOVER_RESET;
    end else if (cfg_wr && (paddr[2] == chct_pkg::REG_ROLLOVER)) begin
      rollover_ticks <= pwdata[chct_pkg::TICKS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      chct_pkg::REG_ROLLOVER: prdata = {16'b0, rollover_ticks};
      default:                prdata = '0;
    endcase
  end

  chct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd_bus  (cmd_bus)
  );

  chct_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd_bus        (cmd_bus),
    .sts            (sts),
    .rollover_ticks (rollover_ticks),
    .cmd            (cmd),
    .address        (address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_address (report_address),
    .report_count   (report_count),
    .report_ticks   (report_ticks),
    .last           (last)
  );

endmodule

// ----- rtl/chct_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// chct_checker
// Port-level checks on the hit counter table, bound to its top level.
// ----------------------------------------------------------------------------
module chct_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [chct_pkg::ADDR_W-1:0]     report_address,
  input logic [chct_pkg::TICKS_W-1:0]    report_ticks
);

  // a word in flight keeps the input side held off
  `ASSERT_NEXT(a_one_word, clk, rst, in_valid && !in_stall, in_stall)

  // every reported entry has seen at least one tick
  `ASSERT_IMPLIES(a_ticks_nonzero, clk, rst, out_valid, report_ticks != '0)

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(report_address))

endmodule

bind call_site_hit_counter_table_top chct_checker u_chct_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .report_address (report_address),
  .report_ticks   (report_ticks)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the call-site hit counter table. A scoreboard keeps
// its own copy of the table, ages it on every tick word and queues the
// rollover reports that each tick should produce; the report channel is
// compared field by field against that queue. Directed words cover address
// zero, the all-ones address, slot reuse and rollover at zero, then random
// phases sweep the rollover setting, fill the table past its size and hold
// the report side off long enough to back the input up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int REG_IDX_ROLLOVER = 0;
  localparam int REG_IDX_SPARE    = 1;   // no register there, writes must be ignored
  localparam int RANDOM_WORDS     = 330;
  localparam int SETTLE_CYCLES    = 2 * chct_pkg::ENTRIES + 8;
  localparam int LONG_HOLD        = 1500;
  localparam int CYCLE_LIMIT      = 2000000;

  typedef enum {PH_MIXED, PH_FILL, PH_PRESSURE} phase_kind_t;

  typedef struct packed {
    logic [chct_pkg::ADDR_W-1:0]  addr;
    logic [chct_pkg::COUNT_W-1:0] hits;
    logic [chct_pkg::TICKS_W-1:0] age;
    logic                         last;
  } report_word_t;

  class report_scoreboard;
    logic [chct_pkg::ADDR_W-1:0]  slot_addr [chct_pkg::ENTRIES];
    logic [chct_pkg::COUNT_W-1:0] slot_hits [chct_pkg::ENTRIES];
    logic [chct_pkg::TICKS_W-1:0] slot_age  [chct_pkg::ENTRIES];
    logic [chct_pkg::TICKS_W-1:0] rollover;
    report_word_t                 expected_reports [$];
    int errors;
    int hit_words;
    int tick_words;
    int zero_hits;
    int dropped_hits;
    int reports_checked;
    int widest_burst;

    function new();
      foreach (slot_addr[i]) begin
        slot_addr[i] = '0;
        slot_hits[i] = '0;
        slot_age[i]  = '0;
      end
      rollover = chct_pkg::ROLLOVER_RESET;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == REG_IDX_ROLLOVER) rollover = value[chct_pkg::TICKS_W-1:0];
    endfunction

    // first slot that holds the address or is empty wins
    function void bump_hit(logic [chct_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < chct_pkg::ENTRIES; i++) begin
        if (slot_addr[i] == a) begin
          if (slot_hits[i] != '1) slot_hits[i]++;
          return;
        end
        if (slot_addr[i] == '0) begin
          slot_addr[i] = a;
          slot_hits[i] = chct_pkg::COUNT_W'(1);
          slot_age[i]  = '0;
          return;
        end
      end
      dropped_hits++;
    endfunction

    function void age_slots();
      report_word_t r;
      int n;
      n = 0;
      for (int i = 0; i < chct_pkg::ENTRIES; i++) begin
        if (slot_addr[i] == '0) continue;
        if (slot_age[i] != '1) slot_age[i]++;
        if (slot_age[i] >= rollover) begin
          r.addr = slot_addr[i];
          r.hits = slot_hits[i];
          r.age  = slot_age[i];
          r.last = 1'b0;
          expected_reports.push_back(r);
          n++;
          slot_addr[i] = '0;
          slot_hits[i] = '0;
          slot_age[i]  = '0;
        end
      end
      if (n > 0) expected_reports[expected_reports.size()-1].last = 1'b1;
      if (n > widest_burst) widest_burst = n;
    endfunction

    function void note_word(logic c, logic [chct_pkg::ADDR_W-1:0] a);
      if (c == chct_pkg::CMD_HIT) begin
        hit_words++;
        if (a == '0) zero_hits++;
        bump_hit(a);
      end else begin
        tick_words++;
        age_slots();
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: report %0d %s expected %h actual %h",
                 $time, reports_checked, name, exp_v, act_v);
      end
    endfunction

    function void check_report(logic [chct_pkg::ADDR_W-1:0] a,
                               logic [chct_pkg::COUNT_W-1:0] h,
                               logic [chct_pkg::TICKS_W-1:0] t, logic l);
      report_word_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report expected none actual %h %h %h %b",
                 $time, a, h, t, l);
        return;
      end
      e = expected_reports.pop_front();
      check_field("report_address", e.addr, a);
      check_field("report_count", e.hits, h);
      check_field("report_ticks", 32'(e.age), 32'(t));
      check_field("last", 32'(e.last), 32'(l));
      reports_checked++;
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [chct_pkg::PADDR_W-1:0]        paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;
  logic                                in_valid;
  logic                                in_stall;
  logic                                cmd;
  logic [chct_pkg::ADDR_W-1:0]         address;
  logic                                out_valid;
  logic                                out_stall;
  logic [chct_pkg::ADDR_W-1:0]         report_address;
  logic [chct_pkg::COUNT_W-1:0]        report_count;
  logic [chct_pkg::TICKS_W-1:0]        report_ticks;
  logic                                last;

  report_scoreboard sb = new();
  bit          hold_req = 1'b0;
  int          words_sent;
  int          burst_left;
  int          settings_used;
  int unsigned cycle_count;

  call_site_hit_counter_table_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .address        (address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_address (report_address),
    .report_count   (report_count),
    .report_ticks   (report_ticks),
    .last           (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_report(report_address, report_count, report_ticks, last);
  end

  // report side stall pattern, with a long hold-off on request
  initial begin
    int mode;
    int len;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 30);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= chct_pkg::PADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic send_word(input logic c, input logic [chct_pkg::ADDR_W-1:0] a);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    address  <= a;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_word(c, a);
    words_sent++;
  endtask

  // bursts of words with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // all reports in, then let any hit or empty tick still in the scan finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input phase_kind_t kind);
    logic [chct_pkg::ADDR_W-1:0] pool [$];
    logic [chct_pkg::ADDR_W-1:0] a;
    int n_words;
    int roll;
    int tick_pct;
    repeat ($urandom_range(1, 12)) pool.push_back($urandom);
    tick_pct = (kind == PH_PRESSURE) ? 45 : $urandom_range(10, 35);
    // more distinct addresses than slots, so later hits are dropped
    if (kind == PH_FILL) begin
      for (int i = 0; i < chct_pkg::ENTRIES + 6; i++) begin
        a = $urandom;
        if (a == '0) a = 1;
        send_word(chct_pkg::CMD_HIT, a);
        pace();
      end
    end
    n_words = $urandom_range(30, 50);
    for (int i = 0; i < n_words; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct)
        send_word(chct_pkg::CMD_TICK, $urandom);
      else if (roll < tick_pct + 8)
        send_word(chct_pkg::CMD_HIT, '0);
      else if (roll < tick_pct + 14)
        send_word(chct_pkg::CMD_HIT, $urandom);
      else
        send_word(chct_pkg::CMD_HIT, pool[$urandom_range(0, pool.size() - 1)]);
      pace();
    end
    drain();
  endtask

  initial begin
    int random_start;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    cmd      = chct_pkg::CMD_HIT;
    address  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset rollover still in force: zero address bumps an empty slot,
    // then a real address takes that slot and restarts its count
    send_word(chct_pkg::CMD_HIT, '0);
    send_word(chct_pkg::CMD_HIT, '0);
    send_word(chct_pkg::CMD_HIT, '1);
    send_word(chct_pkg::CMD_HIT, 32'h0000_0001);
    send_word(chct_pkg::CMD_HIT, '1);
    send_word(chct_pkg::CMD_HIT, '0);
    send_word(chct_pkg::CMD_TICK, 32'h5555_5555);
    drain();

    // rollover at zero: every occupied slot reports on the next tick
    write_reg(REG_IDX_ROLLOVER, 32'd0);
    send_word(chct_pkg::CMD_TICK, 32'hAAAA_AAAA);
    send_word(chct_pkg::CMD_TICK, '0);
    send_word(chct_pkg::CMD_HIT, 32'h8000_0000);
    send_word(chct_pkg::CMD_TICK, '1);
    drain();

    // upper data bits and the unmapped address must both be ignored
    write_reg(REG_IDX_SPARE, 32'h0000_0005);
    write_reg(REG_IDX_ROLLOVER, 32'hFFFF_0002);
    send_word(chct_pkg::CMD_HIT, 32'hA5A5_A5A5);
    send_word(chct_pkg::CMD_HIT, 32'h5A5A_5A5A);
    send_word(chct_pkg::CMD_TICK, 32'h0F0F_0F0F);
    send_word(chct_pkg::CMD_HIT, 32'h1234_5678);
    send_word(chct_pkg::CMD_TICK, 32'hF0F0_F0F0);
    send_word(chct_pkg::CMD_TICK, 32'h0000_0000);
    drain();

    random_start = words_sent;
    for (int p = 0; words_sent - random_start < RANDOM_WORDS; p++) begin
      case (p % 7)
        0: begin
          write_reg(REG_IDX_ROLLOVER, 32'd1);
          run_phase(PH_MIXED);
        end
        1: begin
          write_reg(REG_IDX_ROLLOVER, 32'd65535);
          run_phase(PH_MIXED);
        end
        2: begin
          write_reg(REG_IDX_ROLLOVER, 32'd1);
          run_phase(PH_FILL);
        end
        3: begin
          write_reg(REG_IDX_ROLLOVER, 32'd0);
          run_phase(PH_MIXED);
        end
        4: begin
          write_reg(REG_IDX_ROLLOVER, 32'(chct_pkg::ROLLOVER_RESET));
          run_phase(PH_MIXED);
        end
        5: begin
          write_reg(REG_IDX_ROLLOVER, $urandom_range(1, 4));
          hold_req = 1'b1;
          run_phase(PH_PRESSURE);
        end
        default: begin
          write_reg(REG_IDX_ROLLOVER, $urandom_range(1, 16));
          run_phase(PH_MIXED);
        end
      endcase
    end

    if (sb.expected_reports.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected reports never arrived", $time,
               sb.expected_reports.size());
    end
    $display("covered %0d words (%0d hits, %0d of them address zero, %0d ticks), %0d reports",
             words_sent, sb.hit_words, sb.zero_hits, sb.tick_words, sb.reports_checked);
    $display("%0d hits dropped on a full table, widest tick burst %0d, %0d register writes",
             sb.dropped_hits, sb.widest_burst, settings_used);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
